// ----- rtl/core/btedc_pkg.sv -----
// shared types and constants for the banded transposition edit distance block
// no dependencies
`default_nettype none

package btedc_pkg;

    localparam int MAX_LEN_DEF = 32;
    // covers every score for the supported string lengths (up to 64)
    localparam int DIST_W      = 7;
    localparam logic [5:0] CUTOFF_CAP = 6'd32;

    localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [1:0] OP_COMPUTE     = 2'd2;
    localparam logic [1:0] OP_NONE        = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_byte;
        logic [5:0] max_distance;
    } btedc_in_t;

    typedef struct packed {
        logic [5:0] distance;
        logic       over_cutoff;
        logic       length_overflow;
    } btedc_out_t;

    // what one cell hands to its right neighbor
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              not_first;
        logic [7:0]        a_char;
        logic [7:0]        b_char;
        logic [DIST_W-1:0] cur;
        logic [DIST_W-1:0] prev;
        logic [DIST_W-1:0] diag2;
    } btedc_link_t;

endpackage

`default_nettype wire

// ----- rtl/core/btedc_cell.sv -----
// one column cell of the systolic edit distance chain
// depends on btedc_pkg
`default_nettype none

module btedc_cell
    import btedc_pkg::*;
#(
    parameter int COL = 1
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic        wr_en,
    input  wire logic [7:0]  wr_char,
    input  wire logic        wr_sel,
    input  wire btedc_link_t left,
    output btedc_link_t      right
);

    logic              vld_reg, last_reg, nf_reg;
    logic [7:0]        a_reg, b_reg;
    logic [DIST_W-1:0] cur_reg, prev_reg, diag_reg, diag2_reg;
    logic [DIST_W:0]   c_up, c_left, c_diag, c_trans, best;
    logic              trans_ok;
    logic [DIST_W-1:0] cur_next;

    always_comb begin
        c_up    = {1'b0, cur_reg} + 1'b1;
        c_left  = {1'b0, left.cur} + 1'b1;
        c_diag  = {1'b0, left.prev} + {{DIST_W{1'b0}}, (left.a_char != b_reg)};
        c_trans = {1'b0, left.diag2} + 1'b1;
        // adjacent swap: a_i == b_(j-1) and a_(i-1) == b_j
        trans_ok = (COL > 1) && left.not_first && (left.a_char == left.b_char)
                   && (a_reg == b_reg);
        best = c_up;
        if (c_left < best) begin
            best = c_left;
        end
        if (c_diag < best) begin
            best = c_diag;
        end
        if (trans_ok && (c_trans < best)) begin
            best = c_trans;
        end
        cur_next = best[DIST_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (start) begin
            // a new compute flushes rows still crossing the chain
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= left.valid;
        end
        if (wr_en && wr_sel) begin
            b_reg <= wr_char;
        end
        if (start) begin
            cur_reg <= DIST_W'(COL);
        end else if (left.valid) begin
            cur_reg   <= cur_next;
            prev_reg  <= cur_reg;
            diag_reg  <= left.prev;
            diag2_reg <= diag_reg;
            a_reg     <= left.a_char;
            nf_reg    <= left.not_first;
            last_reg  <= left.last;
        end
    end

    always_comb begin
        right.valid     = vld_reg;
        right.last      = last_reg;
        right.not_first = nf_reg;
        right.a_char    = a_reg;
        right.b_char    = b_reg;
        right.cur       = cur_reg;
        right.prev      = prev_reg;
        right.diag2     = diag2_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/core/banded_transposition_edit_distance.sv -----
// top level of the banded transposition edit distance block
// depends on btedc_pkg and btedc_cell
`default_nettype none

// Optimal string alignment distance (insert, delete, substitute, swap of two
// adjacent characters, each costing one) between two byte strings of up to
// MAX_LEN characters. Opcode 0 appends a byte to the first string, opcode 1 to
// the second; each load is one transfer and gives no result.
// Opcode 2 computes with cutoff min(max_distance, 32) and returns one result:
// the distance if it is at most the cutoff, else cutoff+1 with over_cutoff set.
// A string loaded past MAX_LEN flags length_overflow and forces cutoff+1.
// Compute clears both strings. The second string sits in a chain of MAX_LEN
// cells, one per column; the first string streams through the chain one
// character per cycle from a small memory. A compute runs until the last
// row reaches the column of the last second-string character; the result
// then passes the result register and, once the output register is free,
// that output register, which drives m_. Empty strings and overflow skip
// the table walk and go straight to the result register. Inputs are held
// off while a compute runs and while its result waits for the output
// register; once the result sits there, loads are taken while it waits on m_.
module banded_transposition_edit_distance
    import btedc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire btedc_in_t  s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output btedc_out_t      m_data
);

    localparam int LW = $clog2(MAX_LEN + 2);
    localparam int AW = $clog2(MAX_LEN);
    localparam int IW = $clog2(MAX_LEN + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [LW-1:0] first_len_reg, second_len_reg;
    logic [LW-1:0] run_la_reg, run_lb_reg, iss_reg;
    logic [5:0]    cut_reg;
    btedc_out_t    res_reg;
    btedc_out_t    m_data_reg;
    logic          m_valid_reg;

    // first string memory, registered read
    logic [7:0]    first_mem [MAX_LEN];
    logic [7:0]    rd_data_reg;
    logic          hv_reg, hlast_reg, hnf_reg;
    logic [LW-1:0] hrow_reg;

    btedc_link_t   links [MAX_LEN+1];
    btedc_link_t   sel_link;

    logic          s_xfer, is_load_a, is_load_b, is_comp;
    logic          start;
    logic          issue;
    logic [5:0]    cut_in;
    logic          ovf_in;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign is_load_a = s_xfer && (s_data.opcode == OP_LOAD_FIRST);
    assign is_load_b = s_xfer && (s_data.opcode == OP_LOAD_SECOND);
    assign is_comp   = s_xfer && (s_data.opcode == OP_COMPUTE);
    assign cut_in    = (s_data.max_distance > CUTOFF_CAP) ? CUTOFF_CAP
                                                          : s_data.max_distance;
    assign ovf_in    = (first_len_reg > LW'(MAX_LEN)) || (second_len_reg > LW'(MAX_LEN));
    assign start     = is_comp;
    assign issue     = (state_reg == ST_RUN) && (iss_reg < run_la_reg);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // clamp a raw score to the cutoff
    function automatic btedc_out_t finish_res(input logic [7:0] d, input logic [5:0] cut,
                                              input logic ovf);
        btedc_out_t r;
        r.length_overflow = ovf;
        if (ovf || (d > {2'b00, cut})) begin
            r.distance    = cut + 6'd1;
            r.over_cutoff = 1'b1;
        end else begin
            r.distance    = d[5:0];
            r.over_cutoff = 1'b0;
        end
        return r;
    endfunction

    // memory write on first string load, read for the streaming head
    always_ff @(posedge aclk) begin
        if (is_load_a && (first_len_reg < LW'(MAX_LEN))) begin
            first_mem[first_len_reg[AW-1:0]] <= s_data.char_byte;
        end
        if (issue) begin
            rd_data_reg <= first_mem[iss_reg[AW-1:0]];
            hlast_reg   <= ((iss_reg + 1'b1) == run_la_reg);
            hnf_reg     <= (iss_reg != '0);
            hrow_reg    <= iss_reg + 1'b1;
        end
    end

    // head of the chain: column zero of the table
    always_comb begin
        links[0].valid     = hv_reg;
        links[0].last      = hlast_reg;
        links[0].not_first = hnf_reg;
        links[0].a_char    = rd_data_reg;
        links[0].b_char    = 8'd0;
        links[0].cur       = DIST_W'(hrow_reg);
        links[0].prev      = DIST_W'(hrow_reg - 1'b1);
        links[0].diag2     = '0;
    end

    for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
        btedc_cell #(
            .COL (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (start),
            .wr_en   (is_load_b),
            .wr_char (s_data.char_byte),
            .wr_sel  (second_len_reg == LW'(g - 1)),
            .left    (links[g-1]),
            .right   (links[g])
        );
    end

    // column of the last second-string character
    assign sel_link = links[run_lb_reg[IW-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            m_valid_reg    <= 1'b0;
            hv_reg         <= 1'b0;
            iss_reg        <= '0;
        end else begin
            hv_reg <= issue;
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            if (is_load_a && (first_len_reg <= LW'(MAX_LEN))) begin
                first_len_reg <= first_len_reg + 1'b1;
            end
            if (is_load_b && (second_len_reg <= LW'(MAX_LEN))) begin
                second_len_reg <= second_len_reg + 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (is_comp) begin
                        first_len_reg  <= '0;
                        second_len_reg <= '0;
                        run_la_reg     <= first_len_reg;
                        run_lb_reg     <= second_len_reg;
                        cut_reg        <= cut_in;
                        iss_reg        <= '0;
                        // empty strings and overflow need no table walk
                        if (ovf_in) begin
                            res_reg   <= finish_res(8'd0, cut_in, 1'b1);
                            state_reg <= ST_FINISH;
                        end else if (first_len_reg == '0) begin
                            res_reg   <= finish_res(8'(second_len_reg), cut_in, 1'b0);
                            state_reg <= ST_FINISH;
                        end else if (second_len_reg == '0) begin
                            res_reg   <= finish_res(8'(first_len_reg), cut_in, 1'b0);
                            state_reg <= ST_FINISH;
                        end else begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                    if (sel_link.valid && sel_link.last) begin
                        res_reg   <= finish_res(8'(sel_link.cur), cut_reg, 1'b0);
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
